// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the flow state tracker.
// Depends on nothing; synthesis builds define SYNTHESIS to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pfst_pkg.sv =====
// Types, codes and constants of the flow state tracker.
// Used by pfst_fsm and the top level of the block; depends on nothing.
package pfst_pkg;

    localparam int FLOW_ENTRIES = 256;
    localparam int FLOW_AW      = $clog2(FLOW_ENTRIES);

    localparam logic [2:0] ST_ZERO        = 3'd0;
    localparam logic [2:0] ST_UNIFLOW     = 3'd1;
    localparam logic [2:0] ST_ASSOCIATING = 3'd2;
    localparam logic [2:0] ST_ASSOCIATED  = 3'd3;
    localparam logic [2:0] ST_STOPWAIT    = 3'd4;
    localparam logic [2:0] ST_STOPPING    = 3'd5;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] CFG_IDLE_TIMEOUT       = 2'd0;
    localparam logic [1:0] CFG_ASSOCIATED_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_STOP_TIMEOUT       = 2'd2;

    localparam logic [15:0] IDLE_TIMEOUT_RST       = 16'd100;
    localparam logic [15:0] ASSOCIATED_TIMEOUT_RST = 16'd30;
    localparam logic [15:0] STOP_TIMEOUT_RST       = 16'd20;

    typedef struct packed {
        logic [7:0]  flow_index;
        logic        new_flow;
        logic [31:0] source_address;
        logic        stop_flag;
        logic [31:0] packet_serial;
        logic [31:0] echoed_serial;
    } pfst_in_t;

    typedef struct packed {
        logic [2:0]  flow_state;
        logic [1:0]  timer_command;
        logic [15:0] timeout_value;
    } pfst_out_t;

    // One flow entry as it sits in the state memory.
    typedef struct packed {
        logic [2:0]  state;
        logic [31:0] reference_source;
        logic [31:0] associating_serial;
        logic [31:0] stopwait_serial;
    } entry_t;

    typedef struct packed {
        logic [15:0] idle_timeout;
        logic [15:0] associated_timeout;
        logic [15:0] stop_timeout;
    } timeouts_t;

endpackage

// ===== rtl/pfst_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module pfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/pfst_fsm.sv =====
// Per-packet state transition of one flow entry: new entry and result.
// Depends on pfst_pkg.
module pfst_fsm
    import pfst_pkg::*;
(
    input  pfst_in_t  item,
    input  entry_t    cur,
    input  timeouts_t tmo,
    output entry_t    upd,
    output pfst_out_t res
);

    logic [2:0]  st;
    logic [31:0] serial_diff;
    logic        pse_after;
    logic        same_src;

    // Serial order: after means a forward distance of 1 .. 2^31-1.
    assign serial_diff = item.echoed_serial - cur.associating_serial;
    assign pse_after   = (serial_diff != 32'd0) && !serial_diff[31];
    assign same_src    = (cur.reference_source == item.source_address);
    assign st          = item.new_flow ? ST_ZERO : cur.state;

    always_comb
    begin
        upd               = cur;
        upd.state         = st;
        res.flow_state    = st;
        res.timer_command = CMD_NONE;
        res.timeout_value = 16'd0;
        unique case (st)
            ST_ZERO:
            begin
                upd.state              = ST_UNIFLOW;
                upd.reference_source   = item.source_address;
                res.flow_state         = ST_UNIFLOW;
                res.timer_command      = CMD_START;
                res.timeout_value      = tmo.idle_timeout;
            end
            ST_UNIFLOW:
            begin
                res.timer_command = CMD_RESTART;
                res.timeout_value = tmo.idle_timeout;
                if (!same_src)
                begin
                    upd.state              = ST_ASSOCIATING;
                    upd.associating_serial = item.packet_serial;
                    res.flow_state         = ST_ASSOCIATING;
                end
            end
            ST_ASSOCIATING:
            begin
                res.timer_command = CMD_RESTART;
                res.timeout_value = tmo.idle_timeout;
                if (same_src && pse_after)
                begin
                    upd.state      = ST_ASSOCIATED;
                    res.flow_state = ST_ASSOCIATED;
                end
            end
            ST_ASSOCIATED:
            begin
                res.timer_command = CMD_RESTART;
                res.timeout_value = tmo.associated_timeout;
                if (item.stop_flag)
                begin
                    upd.state            = ST_STOPWAIT;
                    upd.reference_source = item.source_address;
                    upd.stopwait_serial  = item.packet_serial;
                    res.flow_state       = ST_STOPWAIT;
                end
            end
            ST_STOPWAIT:
            begin
                res.timer_command = CMD_RESTART;
                res.timeout_value = tmo.associated_timeout;
                if (item.stop_flag && !same_src &&
                    (cur.stopwait_serial == item.echoed_serial))
                begin
                    upd.state         = ST_STOPPING;
                    res.flow_state    = ST_STOPPING;
                    res.timeout_value = tmo.stop_timeout;
                end
            end
            default:
            begin
                // Stopping, and codes that cannot be stored, keep their state.
            end
        endcase
    end

endmodule

// ===== rtl/plus_flow_state_tracker.sv =====
// Top level of the flow state tracker: command port, configuration, state memory.
// Depends on pfst_pkg, pfst_ram, pfst_fsm and assert_macros.svh.
//
// Usage: a packet header is presented on item and transferred at a rising edge
// where start is high and busy is low. The flow entry named by item.flow_index
// is read from the state memory at that edge, updated in the next cycle and
// written back at the edge that ends it. The result (new flow state, timer
// command and timeout) is then registered on result and held, marked for one cycle
// by done. busy is high in the update cycle, so no new header is taken until
// the current one has been written back; the pace is set by the registered
// read of the state memory followed by the update and write-back cycle. Because
// the write lands before the next read can be issued, back-to-back packets of
// the same flow always see fresh state.
// The receiver cannot stall: a result is transferred in the cycle it shows.
// Timeouts are written through the cfg_* channel, which is always ready; the
// user must use it only while the block is idle; the block does not enforce it.
// A write to an index past the register list is accepted and ignored. Reset
// clears the control state and loads the default timeouts; flow entries are
// undefined until a new_flow packet has written them, so no clearing pass is needed.
`include "assert_macros.svh"

module plus_flow_state_tracker
    import pfst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pfst_in_t    item,
    output logic        done,
    output pfst_out_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    timeouts_t tmo_reg;
    logic      busy_reg;
    logic      done_reg;
    pfst_in_t  item_reg;
    pfst_out_t result_reg;

    logic               accept;
    logic [FLOW_AW-1:0] rd_idx;
    logic [FLOW_AW-1:0] wr_idx;
    logic [$bits(entry_t)-1:0] rd_word;
    entry_t             cur_entry;
    entry_t             upd_entry;
    pfst_out_t          res_next;

    assign accept    = start && !busy_reg;
    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign done      = done_reg;
    assign result    = result_reg;

    // Flow index reduced to the memory's address range.
    assign rd_idx = FLOW_AW'(item.flow_index % FLOW_ENTRIES);
    assign wr_idx = FLOW_AW'(item_reg.flow_index % FLOW_ENTRIES);

    // User must write configuration registers only while no packet is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg.idle_timeout       <= IDLE_TIMEOUT_RST;
            tmo_reg.associated_timeout <= ASSOCIATED_TIMEOUT_RST;
            tmo_reg.stop_timeout       <= STOP_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDLE_TIMEOUT:       tmo_reg.idle_timeout       <= cfg_data;
                CFG_ASSOCIATED_TIMEOUT: tmo_reg.associated_timeout <= cfg_data;
                CFG_STOP_TIMEOUT:       tmo_reg.stop_timeout       <= cfg_data;
                default:
                begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // busy covers the update cycle; done marks the result cycle after it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (busy_reg)
        begin
            result_reg <= res_next;
        end
    end

    pfst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (FLOW_ENTRIES)
    ) u_state_ram (
        .clk   (clk),
        .we    (busy_reg),
        .waddr (wr_idx),
        .wdata (upd_entry),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (rd_word)
    );

    assign cur_entry = entry_t'(rd_word);

    pfst_fsm u_fsm (
        .item (item_reg),
        .cur  (cur_entry),
        .tmo  (tmo_reg),
        .upd  (upd_entry),
        .res  (res_next)
    );

    // A transfer always leads to the update cycle, and that to the result cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    `ASSERT_NEXT(a_busy_done, clk, rst_n, busy_reg, done_reg && !busy_reg)
    // A result cycle is never also an update cycle: busy is low while done is high.
    `ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    // A result without a timer command carries no timeout.
    `ASSERT_SAME(a_none_zero, clk, rst_n, done_reg && (result_reg.timer_command == CMD_NONE), result_reg.timeout_value == 16'd0)

endmodule

// ===== sim/plus_flow_state_tracker_tb.sv =====
// Self-checking testbench for plus_flow_state_tracker: per-flow PLUS state tracking.
// Holds a scoreboard class with its own flow-state predictor; depends only on pfst_pkg
// and the RTL of the block.
module plus_flow_state_tracker_tb
    import pfst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 lies past the register list; the block must take it and ignore it.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // Tracks every flow exactly as the block should: one entry per flow index, the
    // three timeouts, and the queue of outcomes still owed by the block.
    class flow_scoreboard;
        logic [15:0] idle_tmo;
        logic [15:0] assoc_tmo;
        logic [15:0] stop_tmo;
        logic [2:0]  flow_state [FLOW_ENTRIES];
        logic [31:0] ref_src    [FLOW_ENTRIES];
        logic [31:0] assoc_psn  [FLOW_ENTRIES];
        logic [31:0] stop_psn   [FLOW_ENTRIES];
        pfst_out_t   pending    [$];
        int          errors;
        int          checked;
        int          associations;
        int          stops;

        function new();
            idle_tmo  = IDLE_TIMEOUT_RST;
            assoc_tmo = ASSOCIATED_TIMEOUT_RST;
            stop_tmo  = STOP_TIMEOUT_RST;
            for (int i = 0; i < FLOW_ENTRIES; i++)
            begin
                flow_state[i] = ST_ZERO;
                ref_src[i]    = '0;
                assoc_psn[i]  = '0;
                stop_psn[i]   = '0;
            end
            errors       = 0;
            checked      = 0;
            associations = 0;
            stops        = 0;
        endfunction

        function void flag(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        // Serial-number order: a is after b when the 32-bit difference is
        // positive and below half the number space.
        function bit serial_after(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return (d != 32'd0) && !d[31];
        endfunction

        function void configure(logic [1:0] index, logic [15:0] value);
            case (index)
                CFG_IDLE_TIMEOUT:       idle_tmo  = value;
                CFG_ASSOCIATED_TIMEOUT: assoc_tmo = value;
                CFG_STOP_TIMEOUT:       stop_tmo  = value;
                default: ;
            endcase
        endfunction

        function void note_header(pfst_in_t hdr);
            int unsigned slot;
            logic [2:0]  st;
            pfst_out_t   outcome;
            slot = hdr.flow_index % FLOW_ENTRIES;
            st = hdr.new_flow ? ST_ZERO : flow_state[slot];
            outcome.timer_command = CMD_NONE;
            outcome.timeout_value = '0;
            case (st)
                ST_ZERO:
                begin
                    st = ST_UNIFLOW;
                    outcome.timer_command = CMD_START;
                    outcome.timeout_value = idle_tmo;
                    ref_src[slot] = hdr.source_address;
                end
                ST_UNIFLOW:
                begin
                    outcome.timer_command = CMD_RESTART;
                    outcome.timeout_value = idle_tmo;
                    if (ref_src[slot] != hdr.source_address)
                    begin
                        st = ST_ASSOCIATING;
                        assoc_psn[slot] = hdr.packet_serial;
                    end
                end
                ST_ASSOCIATING:
                begin
                    outcome.timer_command = CMD_RESTART;
                    outcome.timeout_value = idle_tmo;
                    if (ref_src[slot] == hdr.source_address &&
                        serial_after(hdr.echoed_serial, assoc_psn[slot]))
                    begin
                        st = ST_ASSOCIATED;
                        associations++;
                    end
                end
                ST_ASSOCIATED:
                begin
                    outcome.timer_command = CMD_RESTART;
                    outcome.timeout_value = assoc_tmo;
                    if (hdr.stop_flag)
                    begin
                        st = ST_STOPWAIT;
                        ref_src[slot]  = hdr.source_address;
                        stop_psn[slot] = hdr.packet_serial;
                    end
                end
                ST_STOPWAIT:
                begin
                    outcome.timer_command = CMD_RESTART;
                    outcome.timeout_value = assoc_tmo;
                    if (hdr.stop_flag && ref_src[slot] != hdr.source_address &&
                        stop_psn[slot] == hdr.echoed_serial)
                    begin
                        st = ST_STOPPING;
                        outcome.timeout_value = stop_tmo;
                        stops++;
                    end
                end
                default: ;
            endcase
            flow_state[slot] = st;
            outcome.flow_state = st;
            pending.push_back(outcome);
        endfunction

        function void check_result(pfst_out_t got);
            pfst_out_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("unexpected result: state %0d, command %0d, timeout %0d",
                               got.flow_state, got.timer_command, got.timeout_value));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.flow_state !== want.flow_state)
                flag($sformatf("flow_state mismatch: expected %0d, actual %0d",
                               want.flow_state, got.flow_state));
            if (got.timer_command !== want.timer_command)
                flag($sformatf("timer_command mismatch: expected %0d, actual %0d",
                               want.timer_command, got.timer_command));
            if (got.timeout_value !== want.timeout_value)
                flag($sformatf("timeout_value mismatch: expected %0d, actual %0d",
                               want.timeout_value, got.timeout_value));
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    pfst_in_t    item      = '0;
    logic        done;
    pfst_out_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    flow_scoreboard sb = new();

    // A flow entry becomes readable only after a header with new_flow has written
    // it; the stimulus never touches an entry that is still undefined.
    bit flow_live [FLOW_ENTRIES];
    int headers_sent = 0;
    int settings_used = 1;

    plus_flow_state_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Results cannot be held off, so every cycle with done high is a transfer.
    // Signals are read right after the edge, before the design's own updates land,
    // which gives the values that the edge itself saw.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic pfst_in_t make_header(logic [7:0] index, logic fresh,
                                             logic [31:0] src, logic stop,
                                             logic [31:0] psn, logic [31:0] pse);
        pfst_in_t hdr;
        hdr.flow_index     = index;
        hdr.new_flow       = fresh;
        hdr.source_address = src;
        hdr.stop_flag      = stop;
        hdr.packet_serial  = psn;
        hdr.echoed_serial  = pse;
        return hdr;
    endfunction

    // Builds the next random header. Most headers follow the flow's current state
    // so that flows walk all the way to stopping; the rest are random noise.
    function automatic pfst_in_t next_header();
        pfst_in_t    hdr;
        logic [2:0]  st;
        logic [31:0] flip;
        logic [31:0] peer_src;
        hdr.flow_index     = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 7));
        hdr.new_flow       = ($urandom_range(0, 31) == 0);
        hdr.source_address = $urandom;
        hdr.stop_flag      = 1'($urandom_range(0, 1));
        hdr.packet_serial  = $urandom;
        hdr.echoed_serial  = $urandom;
        if (!flow_live[hdr.flow_index])
            hdr.new_flow = 1'b1;
        st = sb.flow_state[hdr.flow_index];
        // Recycle finished flows often, otherwise they pile up in stopping.
        if (st == ST_STOPPING && $urandom_range(0, 1) == 1)
            hdr.new_flow = 1'b1;
        flip = $urandom;
        if (flip == 32'd0)
            flip = 32'd1;
        peer_src = sb.ref_src[hdr.flow_index] ^ flip;
        if (!hdr.new_flow && $urandom_range(0, 9) < 8)
        begin
            case (st)
                ST_UNIFLOW:
                    hdr.source_address = ($urandom_range(0, 3) != 0)
                                         ? peer_src : sb.ref_src[hdr.flow_index];
                ST_ASSOCIATING:
                begin
                    hdr.source_address = sb.ref_src[hdr.flow_index];
                    // Mostly a later echo; sometimes an equal or earlier one.
                    if ($urandom_range(0, 9) < 7)
                        hdr.echoed_serial = sb.assoc_psn[hdr.flow_index] +
                                            $urandom_range(1, 1000);
                    else
                        hdr.echoed_serial = sb.assoc_psn[hdr.flow_index] -
                                            $urandom_range(0, 3);
                end
                ST_ASSOCIATED:
                    hdr.stop_flag = ($urandom_range(0, 2) == 0);
                ST_STOPWAIT:
                begin
                    hdr.stop_flag = ($urandom_range(0, 4) != 0);
                    hdr.source_address = ($urandom_range(0, 4) != 0)
                                         ? peer_src : sb.ref_src[hdr.flow_index];
                    if ($urandom_range(0, 3) != 0)
                        hdr.echoed_serial = sb.stop_psn[hdr.flow_index];
                end
                default: ;
            endcase
        end
        return hdr;
    endfunction

    // Presents one header and waits for its transfer. start stays high into the
    // next header when no gap is drawn, so it is never lowered and raised in the
    // same step.
    task automatic send_header(input pfst_in_t hdr, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= hdr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (hdr.new_flow)
            flow_live[hdr.flow_index] = 1'b1;
        sb.note_header(hdr);
        headers_sent++;
    endtask

    // Stops sending, waits for every outstanding result and then idles on so that
    // the block is surely idle before any register write.
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.pending.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending.size() != 0)
        begin
            sb.flag($sformatf("%0d results never arrived", sb.pending.size()));
            sb.pending.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // Writes the three timeouts back to back; optionally ends with a write to the
    // unused index, which must leave all of them unchanged.
    task automatic program_timeouts(input logic [15:0] idle, input logic [15:0] assoc,
                                    input logic [15:0] stp, input bit poke_unused);
        logic [1:0]  index_list [4];
        logic [15:0] value_list [4];
        int          count;
        index_list = '{CFG_IDLE_TIMEOUT, CFG_ASSOCIATED_TIMEOUT, CFG_STOP_TIMEOUT,
                       CFG_UNUSED_INDEX};
        value_list = '{idle, assoc, stp, 16'($urandom)};
        count = poke_unused ? 4 : 3;
        for (int i = 0; i < count; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= index_list[i];
            cfg_data  <= value_list[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.configure(index_list[i], value_list[i]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int count);
        bit burst;
        burst = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            // Toggle now and then between random gaps and back-to-back headers.
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            send_header(next_header(), burst);
        end
    endtask

    // Directed walk through every state with the reset timeouts. Flow 0 hits the
    // serial-order edges (equal, exactly half the space, just past half, and the
    // wrap from all ones to zero), a wrong source while associating, and every
    // way to miss the stop confirmation. Flow 255 checks new_flow on a live entry
    // and the largest forward serial step.
    task automatic run_directed();
        send_header(make_header(8'd0, 1'b1, 32'h0000_0000, 1'b0, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                                32'h0), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b0, 32'h0,
                                32'hFFFF_FFFF), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b0, 32'h0,
                                32'h7FFF_FFFF), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b0, 32'h0,
                                32'h8000_0000), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678,
                                32'h0), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b0, 32'h0,
                                32'h1234_5678), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0,
                                32'h1234_5678), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b1, 32'h0,
                                32'h1234_5679), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'h0000_0000, 1'b1, 32'h0,
                                32'h1234_5678), 1'b0);
        send_header(make_header(8'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF), 1'b0);
        send_header(make_header(8'd0, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd255, 1'b1, 32'hA5A5_5A5A, 1'b0, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd255, 1'b1, 32'h5A5A_A5A5, 1'b0, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd255, 1'b0, 32'hA5A5_5A5A, 1'b0, 32'h8000_0000,
                                32'h0), 1'b0);
        send_header(make_header(8'd255, 1'b0, 32'h5A5A_A5A5, 1'b0, 32'h0,
                                32'hFFFF_FFFF), 1'b0);
        send_header(make_header(8'd255, 1'b0, 32'hA5A5_5A5A, 1'b1, 32'h0, 32'h0), 1'b0);
        send_header(make_header(8'd255, 1'b0, 32'h5A5A_A5A5, 1'b1, 32'h0, 32'h0), 1'b0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timeouts first, then the extremes and a few mixed settings.
        run_directed();
        drain();
        program_timeouts(16'h0000, 16'h0000, 16'h0000, 1'b0);
        run_random(250);
        drain();
        program_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_random(250);
        drain();
        program_timeouts(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        run_random(250);
        drain();
        program_timeouts(16'h0001, 16'h8000, 16'h7FFF, 1'b0);
        run_random(250);
        drain();

        $display("Sent %0d packet headers under %0d timeout settings; %0d results checked.",
                 headers_sent, settings_used, sb.checked);
        $display("Flows became associated %0d times and reached stopping %0d times.",
                 sb.associations, sb.stops);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a correct run ends far earlier than this.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
